// ===== sv/efc_pkg.sv =====
package efc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [13:0] LEN_MAX  = 14'd9999;
  localparam logic [7:0]  CHAR_HASH = 8'h23;
  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_A    = 8'h61;
  localparam int          QDEPTH   = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [13:0] segment_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
  } out_word_t;

  // One classified input word as it waits for the output sequencer.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        close_pkt;
    logic [13:0] len;
    logic [15:0] crc;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    PH_HASH0,
    PH_HASH1,
    PH_LEN3,
    PH_LEN2,
    PH_LEN1,
    PH_LEN0,
    PH_DATA,
    PH_CRC3,
    PH_CRC2,
    PH_CRC1,
    PH_CRC0
  } phase_t;

endpackage

// ===== sv/env_packet_framer_crc16_unit.sv =====
// Channel  Ports                          Carries
// input    in_valid, in_stall, in_word    one data byte with first/last marks and length
// output   out_valid, out_stall, out_word one framed byte with run_last and packet_end
//
// A word with no marks gives one output byte, a word opening a packet gives seven (header,
// four length digits, data) and a word closing one gives five (data, four CRC digits).
// One byte leaves per cycle while out_stall is low, so plain data flows at one word per
// cycle; the four-entry queue absorbs header and CRC bursts. An accepted word is written
// into the queue, and its first byte then moves into the output register when emitted.
// Reset empties the queue, clears out_valid and sets the CRC to 0xFFFF; in_stall rises
// only while the queue is full, and out_stall holds the output register while it is valid.
module env_packet_framer_crc16_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  efc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output efc_pkg::out_word_t out_word
);

  efc_pkg::q_stat_t q_stat;
  efc_pkg::entry_t  push_entry;
  efc_pkg::entry_t  head;
  logic             push;
  logic             pop;

  assign in_stall = q_stat.full;

  efc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  efc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  efc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== sv/efc_front.sv =====
module efc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  efc_pkg::in_word_t in_word,
  input  efc_pkg::q_stat_t  q_stat,
  output logic              push,
  output efc_pkg::entry_t   push_entry
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic        close_pkt;
  logic [13:0] len_sat;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = {8'h00, crc[15:8] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ efc_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  assign push = in_valid && !q_stat.full;

  // A one-byte packet cannot be closed in the same word; it stays open.
  assign close_pkt = in_word.last_byte && !in_word.first_byte;
  assign len_sat   = (in_word.segment_length > efc_pkg::LEN_MAX) ?
                     efc_pkg::LEN_MAX : in_word.segment_length;
  assign crc_base  = in_word.first_byte ? efc_pkg::CRC_INIT : crc_r;
  assign crc_new   = crc_fold(crc_base, in_word.data_byte);

  always_comb begin
    crc_nxt = crc_r;
    if (push) begin
      crc_nxt = close_pkt ? efc_pkg::CRC_INIT : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= efc_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  always_comb begin
    push_entry.data_byte  = in_word.data_byte;
    push_entry.first_byte = in_word.first_byte;
    push_entry.close_pkt  = close_pkt;
    push_entry.len        = len_sat;
    push_entry.crc        = crc_new;
  end

endmodule

// ===== sv/efc_queue.sv =====
module efc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  efc_pkg::entry_t  push_entry,
  input  logic             pop,
  output efc_pkg::entry_t  head,
  output efc_pkg::q_stat_t q_stat
);

  localparam int PW = $clog2(efc_pkg::QDEPTH);
  localparam int CW = $clog2(efc_pkg::QDEPTH + 1);

  efc_pkg::entry_t mem_r [efc_pkg::QDEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(efc_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(efc_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(efc_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

// ===== sv/efc_back.sv =====
module efc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  efc_pkg::entry_t    head,
  input  efc_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output efc_pkg::out_word_t out_word
);

  efc_pkg::phase_t    ph_r, ph_nxt, cur_ph;
  logic               act_r, act_nxt;
  logic [13:0]        rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  efc_pkg::out_word_t out_word_r, emit_word;
  logic               load;
  logic               emit;
  logic               done;
  logic [13:0]        rem_src;
  logic [13:0]        pw;
  logic [3:0]         dig;
  logic [13:0]        sub;
  logic [3:0]         nib;

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) begin
      return efc_pkg::CHAR_ZERO + 8'(v);
    end
    return efc_pkg::CHAR_A + 8'(v - 4'd10);
  endfunction

  assign load = !out_valid_r || !out_stall;
  assign emit = load && !q_stat.empty;
  assign pop  = emit && done;

  // A fresh entry starts with the header when it opens a packet.
  assign cur_ph = act_r ? ph_r :
                  (head.first_byte ? efc_pkg::PH_HASH0 : efc_pkg::PH_DATA);

  // Next state.
  always_comb begin
    ph_nxt  = ph_r;
    act_nxt = act_r;
    if (emit) begin
      act_nxt = !done;
      case (cur_ph)
        efc_pkg::PH_HASH0: ph_nxt = efc_pkg::PH_HASH1;
        efc_pkg::PH_HASH1: ph_nxt = efc_pkg::PH_LEN3;
        efc_pkg::PH_LEN3:  ph_nxt = efc_pkg::PH_LEN2;
        efc_pkg::PH_LEN2:  ph_nxt = efc_pkg::PH_LEN1;
        efc_pkg::PH_LEN1:  ph_nxt = efc_pkg::PH_LEN0;
        efc_pkg::PH_LEN0:  ph_nxt = efc_pkg::PH_DATA;
        efc_pkg::PH_DATA:  ph_nxt = efc_pkg::PH_CRC3;
        efc_pkg::PH_CRC3:  ph_nxt = efc_pkg::PH_CRC2;
        efc_pkg::PH_CRC2:  ph_nxt = efc_pkg::PH_CRC1;
        efc_pkg::PH_CRC1:  ph_nxt = efc_pkg::PH_CRC0;
        default:           ph_nxt = efc_pkg::PH_HASH0;
      endcase
    end
  end

  // Decimal digits are peeled off the length one per cycle, while the output is not stalled,
  // by comparing against the multiples of the current power of ten.
  always_comb begin
    rem_src = (cur_ph == efc_pkg::PH_LEN3) ? head.len : rem_r;
    case (cur_ph)
      efc_pkg::PH_LEN3: pw = 14'd1000;
      efc_pkg::PH_LEN2: pw = 14'd100;
      efc_pkg::PH_LEN1: pw = 14'd10;
      default:          pw = 14'd1;
    endcase
    dig = '0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_src >= pw * 14'(k)) begin
        dig = 4'(k);
        sub = pw * 14'(k);
      end
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    emit_word.out_byte   = head.data_byte;
    emit_word.run_last   = 1'b0;
    emit_word.packet_end = 1'b0;
    done                 = 1'b0;
    rem_nxt              = rem_r;
    nib                  = head.crc[3:0];
    case (cur_ph)
      efc_pkg::PH_CRC3: nib = head.crc[15:12];
      efc_pkg::PH_CRC2: nib = head.crc[11:8];
      efc_pkg::PH_CRC1: nib = head.crc[7:4];
      default:          nib = head.crc[3:0];
    endcase
    case (cur_ph)
      efc_pkg::PH_HASH0,
      efc_pkg::PH_HASH1: begin
        emit_word.out_byte = efc_pkg::CHAR_HASH;
      end
      efc_pkg::PH_LEN3,
      efc_pkg::PH_LEN2,
      efc_pkg::PH_LEN1,
      efc_pkg::PH_LEN0: begin
        emit_word.out_byte = efc_pkg::CHAR_ZERO + 8'(dig);
        if (emit) begin
          rem_nxt = rem_src - sub;
        end
      end
      efc_pkg::PH_DATA: begin
        emit_word.out_byte = head.data_byte;
        emit_word.run_last = !head.close_pkt;
        done               = !head.close_pkt;
      end
      efc_pkg::PH_CRC3,
      efc_pkg::PH_CRC2,
      efc_pkg::PH_CRC1: begin
        emit_word.out_byte = hex_char(nib);
      end
      default: begin
        emit_word.out_byte   = hex_char(nib);
        emit_word.run_last   = 1'b1;
        emit_word.packet_end = 1'b1;
        done                 = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = load ? !q_stat.empty : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= efc_pkg::PH_DATA;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
